FILE: src/stbs_pkg.sv
// Package for the sorted table binary search block.
// Holds the table geometry and field widths; no dependencies.
`timescale 1ns / 1ps

package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int BOUND_W     = ADDR_W + 1;

  localparam int DATA_W      = 32;
  localparam int SLOT_W      = 10;
  localparam int COUNT_W     = 11;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic REG_ENTRIES_IN_USE = 1'b0;

  typedef logic                     command_t;
  typedef logic [SLOT_W-1:0]        slot_t;
  typedef logic signed [DATA_W-1:0] value_t;
  typedef logic [COUNT_W-1:0]       count_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [BOUND_W-1:0]       bound_t;

endpackage

FILE: src/stbs_if.sv
// Valid/ready channel interfaces for the search block's item and result streams.
// Depends on stbs_pkg for the payload types.
`timescale 1ns / 1ps

interface stbs_in_if;
  import stbs_pkg::*;

  logic     valid;
  logic     ready;
  command_t command;
  slot_t    slot;
  value_t   value;

  modport source (output valid, output command, output slot, output value, input ready);
  modport sink   (input valid, input command, input slot, input value, output ready);
endinterface

interface stbs_out_if;
  import stbs_pkg::*;

  logic  valid;
  logic  ready;
  logic  found;
  slot_t found_index;

  modport source (output valid, output found, output found_index, input ready);
  modport sink   (input valid, input found, input found_index, output ready);
endinterface

FILE: src/sorted_table_binary_search.sv
// Sorted table binary search: a write gives no result; a search halves the interval
// over the n entries in use at each step, and each step waits on the registered read
// of the table RAM.
// One item is in flight at a time; a finished result waits in a holding register while the output register is occupied.
// Synchronous active-low reset clears control state and entries_in_use; table
// contents are undefined until written.
`timescale 1ns / 1ps

module sorted_table_binary_search (
  input  logic                         clk,
  input  logic                         rst_n,
  stbs_in_if.sink                      in_ch,
  stbs_out_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [stbs_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  logic [stbs_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output logic [stbs_pkg::APB_DATA_W-1:0] cfg_prdata,
  output logic                         cfg_pready
);
  import stbs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0] state_r, state_nxt;
  count_t     count_r, count_nxt;
  bound_t     lo_r, lo_nxt;
  bound_t     hi_r, hi_nxt;
  addr_t      mid_r, mid_nxt;
  value_t     key_r, key_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_found_r, out_found_nxt;
  slot_t      out_idx_r, out_idx_nxt;
  logic       pend_found_r, pend_found_nxt;
  slot_t      pend_idx_r, pend_idx_nxt;

  logic                  in_xfer;
  logic                  cfg_wr;
  logic                  out_free;
  bound_t                hi_init;
  logic                  ram_we;
  addr_t                 ram_waddr;
  logic                  ram_re;
  addr_t                 ram_raddr;
  logic [DATA_W-1:0]     ram_rdata;
  value_t                entry;
  logic                  hit;
  logic                  key_gt;
  bound_t                lo_c;
  bound_t                hi_c;
  logic [BOUND_W:0]      mid_sum;
  logic                  fin;
  logic                  fin_found;
  slot_t                 fin_idx;

  assign in_ch.ready = rst_n && (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[APB_ADDR_W-1] == REG_ENTRIES_IN_USE)
                      ? APB_DATA_W'(count_r) : '0;

  assign hi_init = (32'(count_r) > 32'(TABLE_DEPTH)) ? BOUND_W'(TABLE_DEPTH)
                                                     : BOUND_W'(count_r);

  assign ram_we    = in_xfer && (in_ch.command == CMD_WRITE) &&
                     (32'(in_ch.slot) < 32'(TABLE_DEPTH));
  assign ram_waddr = ADDR_W'(in_ch.slot);

  assign entry  = $signed(ram_rdata);
  assign hit    = (key_r == entry);
  assign key_gt = (key_r > entry);
  assign lo_c   = key_gt ? (BOUND_W'(mid_r) + BOUND_W'(1)) : lo_r;
  assign hi_c   = key_gt ? hi_r : BOUND_W'(mid_r);
  assign mid_sum = {1'b0, lo_c} + {1'b0, hi_c};

  stbs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_ch.value),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    key_nxt        = key_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_found_nxt  = out_found_r;
    out_idx_nxt    = out_idx_r;
    pend_found_nxt = pend_found_r;
    pend_idx_nxt   = pend_idx_r;
    ram_re         = 1'b0;
    ram_raddr      = mid_r;
    fin            = 1'b0;
    fin_found      = 1'b0;
    fin_idx        = '0;

    if (cfg_wr && (cfg_paddr[APB_ADDR_W-1] == REG_ENTRIES_IN_USE)) begin
      count_nxt = cfg_pwdata[COUNT_W-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_ch.command == CMD_SEARCH)) begin
          key_nxt = in_ch.value;
          lo_nxt  = '0;
          hi_nxt  = hi_init;
          if (hi_init == '0) begin
            fin = 1'b1;
          end else begin
            mid_nxt   = ADDR_W'(hi_init >> 1);
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(hi_init >> 1);
            state_nxt = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (hit) begin
          fin       = 1'b1;
          fin_found = 1'b1;
          fin_idx   = SLOT_W'(mid_r);
        end else if (lo_c >= hi_c) begin
          fin = 1'b1;
        end else begin
          lo_nxt    = lo_c;
          hi_nxt    = hi_c;
          mid_nxt   = ADDR_W'(mid_sum[BOUND_W:1]);
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(mid_sum[BOUND_W:1]);
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = pend_found_r;
          out_idx_nxt   = pend_idx_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_found_nxt = fin_found;
        out_idx_nxt   = fin_idx;
        state_nxt     = S_IDLE;
      end else begin
        pend_found_nxt = fin_found;
        pend_idx_nxt   = fin_idx;
        state_nxt      = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    key_r        <= key_nxt;
    out_found_r  <= out_found_nxt;
    out_idx_r    <= out_idx_nxt;
    pend_found_r <= pend_found_nxt;
    pend_idx_r   <= pend_idx_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.found_index = out_idx_r;

  a_cmp_interval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (lo_r < hi_r) && (hi_r <= BOUND_W'(TABLE_DEPTH)))
    else $error("search interval empty or out of range while comparing");

  a_mid_in_interval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (BOUND_W'(mid_r) >= lo_r) && (BOUND_W'(mid_r) < hi_r))
    else $error("midpoint outside the search interval");

  a_not_found_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_idx_r == '0))
    else $error("not-found result carries a nonzero index");

  a_hold_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && !out_free) |=> (state_r == S_HOLD) && out_valid_r)
    else $error("finished result not held while output is busy");

endmodule

FILE: src/stbs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: bench/tb_sorted_table_binary_search.sv
// Self-checking testbench for the sorted table binary search block.
// Depends on stbs_pkg, the stbs_in_if/stbs_out_if channel interfaces and the block itself.
// Loads tables through write items, sets the entry count over APB and checks every search.
`timescale 1ns / 1ps

module tb_sorted_table_binary_search;
  import stbs_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 2000;
  localparam int MAX_PRINTED   = 200;
  localparam int HOLD_OFF_LEN  = 200;

  typedef struct packed {
    logic  found;
    slot_t index;
  } lookup_t;

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [APB_ADDR_W-1:0] cfg_paddr;
  logic [APB_DATA_W-1:0] cfg_pwdata;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  stbs_in_if  in_ch ();
  stbs_out_if out_ch ();

  sorted_table_binary_search DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  value_t  table_copy [TABLE_DEPTH];
  count_t  entry_count;
  lookup_t expected_lookups [$];

  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_off_left;
  int quiet_cycles;
  int mismatch_count;
  int n_checked;
  int n_hits;
  int n_table_writes;
  int n_count_settings;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
  endtask

  function automatic lookup_t predict_lookup(value_t key);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lookup_t r;
    lo = 0;
    hi = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count;
    mid = 0;
    r.found = 1'b0;
    r.index = '0;
    while (!r.found && lo < hi) begin
      mid = (lo + hi) >> 1;
      if (key == table_copy[mid]) begin
        r.found = 1'b1;
      end else if (key > table_copy[mid]) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    if (r.found) begin
      r.index = slot_t'(mid);
    end
    return r;
  endfunction

  task automatic push_item(command_t cmd, slot_t s, value_t v);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.slot    <= s;
    in_ch.value   <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (cmd == CMD_WRITE) begin
      table_copy[s] = v;
      n_table_writes++;
    end else begin
      expected_lookups.push_back(predict_lookup(v));
    end
    @(negedge clk);
  endtask

  task automatic store_entry(int s, value_t v);
    push_item(CMD_WRITE, slot_t'(s), v);
  endtask

  task automatic lookup_key(value_t key);
    push_item(CMD_SEARCH, slot_t'($urandom), key);
  endtask

  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (expected_lookups.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_entry_count(count_t n);
    drain_block();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_ENTRIES_IN_USE, 2'b00};
    cfg_pwdata  <= APB_DATA_W'(n);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    entry_count = n;
    n_count_settings++;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_idle_mode(int mode);
    case (mode % 4)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 45; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 45; end
      default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
    endcase
  endtask

  task automatic load_table(int n, bit narrow, bit keep_sorted);
    int vals [$];
    vals = {};
    for (int i = 0; i < n; i++) begin
      if (narrow) begin
        vals.push_back(int'($urandom_range(16)) - 8);
      end else begin
        vals.push_back(int'($urandom));
      end
    end
    if (keep_sorted) begin
      vals.sort();
    end
    for (int i = 0; i < n; i++) begin
      store_entry(i, value_t'(vals[i]));
    end
  endtask

  function automatic value_t pick_key(int n);
    int r;
    value_t k;
    r = $urandom_range(99);
    if (n > 0 && r < 50) begin
      k = table_copy[$urandom_range(n - 1)];
    end else if (n > 0 && r < 70) begin
      k = table_copy[$urandom_range(n - 1)] + ($urandom_range(1) ? 1 : -1);
    end else if (r < 85) begin
      k = $urandom;
    end else begin
      case ($urandom_range(3))
        0: k = 32'sh8000_0000;
        1: k = 32'sh7FFF_FFFF;
        2: k = 0;
        default: k = -1;
      endcase
    end
    return k;
  endfunction

  // Keys that keep a full-range search on the slots loaded along the two outer paths.
  function automatic value_t pick_edge_key(int slots [$]);
    int r;
    value_t k;
    r = $urandom_range(99);
    if (r < 70) begin
      k = table_copy[slots[$urandom_range(slots.size() - 1)]];
    end else if (r < 85) begin
      k = 32'sh8000_0000;
    end else begin
      k = 32'sh7FFF_FFFF;
    end
    return k;
  endfunction

  task automatic touch_table(int n);
    int s;
    int r;
    r = $urandom_range(99);
    if (n < TABLE_DEPTH && r < 50) begin
      store_entry($urandom_range(TABLE_DEPTH - 1, n), $urandom);
    end else if (n > 0 && r < 90) begin
      s = $urandom_range(n - 1);
      store_entry(s, (s > 0) ? table_copy[s - 1] : table_copy[s]);
    end else if (n > 0) begin
      store_entry($urandom_range(n - 1), $urandom);
    end
  endtask

  task automatic test_empty_table();
    set_idle_mode(0);
    set_entry_count('0);
    lookup_key(32'sh8000_0000);
    lookup_key(0);
    lookup_key(32'sh7FFF_FFFF);
  endtask

  task automatic test_directed_table();
    set_idle_mode(0);
    store_entry(0, 32'sh8000_0000);
    store_entry(1, -5);
    store_entry(2, 0);
    store_entry(3, 0);
    store_entry(4, 7);
    store_entry(5, 32'sh7FFF_FFFF);
    set_entry_count(count_t'(6));
    for (int i = 0; i < 6; i++) begin
      lookup_key(table_copy[i]);
    end
    lookup_key(-6);
    lookup_key(1);
    lookup_key(8);
    lookup_key(32'sh7FFF_FFFE);
    lookup_key(32'sh8000_0001);
    set_entry_count(count_t'(1));
    lookup_key(32'sh8000_0000);
    lookup_key(0);
  endtask

  task automatic test_full_table();
    int slots [$];
    int vals [$];
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    set_idle_mode(3);
    slots = {};
    vals = {};
    lo = 0;
    hi = TABLE_DEPTH;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      slots.push_back(int'(mid));
      hi = mid;
    end
    lo = (TABLE_DEPTH / 2) + 1;
    hi = TABLE_DEPTH;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      slots.push_back(int'(mid));
      lo = mid + 1;
    end
    slots.sort();
    for (int i = 0; i < slots.size(); i++) begin
      vals.push_back(int'($urandom));
    end
    vals.sort();
    for (int i = 0; i < slots.size(); i++) begin
      store_entry(slots[i], value_t'(vals[i]));
    end
    set_entry_count(count_t'(TABLE_DEPTH));
    repeat (60) lookup_key(pick_edge_key(slots));
    set_entry_count('1);
    repeat (20) lookup_key(pick_edge_key(slots));
  endtask

  task automatic test_output_backpressure();
    set_idle_mode(0);
    load_table(32, 1'b0, 1'b1);
    set_entry_count(count_t'(32));
    @(posedge clk);
    hold_off_left = HOLD_OFF_LEN;
    @(negedge clk);
    repeat (30) lookup_key(pick_key(32));
  endtask

  task automatic test_unsorted_table();
    set_idle_mode(2);
    load_table(20, $urandom_range(1) == 1, 1'b0);
    set_entry_count(count_t'(20));
    repeat (30) lookup_key(pick_key(20));
  endtask

  task automatic test_random_traffic();
    int n;
    for (int phase = 0; phase < 8; phase++) begin
      set_idle_mode(phase);
      n = ($urandom_range(9) == 0) ? $urandom_range(200, 80) : $urandom_range(24, 1);
      load_table(n, $urandom_range(2) == 0, 1'b1);
      set_entry_count(count_t'(n));
      repeat (25) begin
        if ($urandom_range(99) < 15) begin
          touch_table(n);
        end else begin
          lookup_key(pick_key(n));
        end
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    lookup_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_lookups.size() == 0) begin
        report_mismatch("search result transfer with no search pending");
      end else begin
        want = expected_lookups.pop_front();
        n_checked++;
        if (want.found) n_hits++;
        if (out_ch.found !== want.found) begin
          report_mismatch($sformatf("found: got %b, expected %b", out_ch.found, want.found));
        end
        if (out_ch.found_index !== want.index) begin
          report_mismatch($sformatf("found_index: got %0d, expected %0d",
                                    out_ch.found_index, want.index));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_WRITE;
    in_ch.slot    = '0;
    in_ch.value   = '0;
    out_ch.ready  = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    entry_count   = '0;
    hold_off_left = 0;
    quiet_cycles  = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) table_copy[i] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_table();
    test_directed_table();
    test_full_table();
    test_output_backpressure();
    test_unsorted_table();
    test_random_traffic();

    drain_block();
    if (expected_lookups.size() != 0) begin
      report_mismatch($sformatf("%0d search results never arrived", expected_lookups.size()));
    end
    $display("Checked %0d search results (%0d hits) after %0d table writes,",
             n_checked, n_hits, n_table_writes);
    $display("across %0d entry count settings from empty to oversized.", n_count_settings);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
